// File: design/sktab_pkg.sv
package sktab_pkg;

  localparam int KEY_W = 64;
  localparam int VAL_PORT_W = 32;
  localparam int POS_PORT_W = 6;
  localparam int COUNT_PORT_W = 7;
  localparam int STATUS_W = 3;
  localparam int OPCODE_W = 2;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_NEW       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNCHANGED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_READ_OK   = 3'd6;

  typedef struct packed {
    logic done;
    logic hit;
  } srch_stat_t;

endpackage

// File: design/sorted_key_value_table_core.sv
// Sorted key-value table. Entries are kept in ascending key order in two
// single-port-write RAMs (keys and values) with registered reads.
// Input beats on s_axis carry an opcode (insert or update, delete, read at a
// sorted position) with a key, a value and a read position. Each input beat
// gives exactly one output beat on m_axis with a status, the slot index, the
// entry read (zero unless a read succeeds) and the entry count afterward.
// An operation takes one beat at a time. An insert or delete runs a binary
// search with a final probe. A new key then moves the entry at the slot and
// every entry above it up one place; a delete moves every entry above the
// slot down one place. Either way one entry moves per cycle through the RAM
// port, and that move dominates.
// A new input beat is taken as soon as the previous operation has finished,
// even while its output beat still waits; if the receiver stalls, the next
// result is held back until the output register is free.
// Reset empties the table at once; RAM contents are not cleared, since only
// entries below the count are ever read.
module sorted_key_value_table_core
  import sktab_pkg::*;
#(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[1:0], entry_key[65:2], entry_value[97:66], read_position[103:98]
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], slot_index[8:3], found_key[72:9], found_value[104:73],
  // entry_count[111:105]
  output logic [111:0] m_axis_tdata
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int KeepW = (VALUE_WIDTH < VAL_PORT_W) ? VALUE_WIDTH : VAL_PORT_W;
  localparam int CmpW  = (CW > POS_PORT_W) ? CW : POS_PORT_W;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DISPATCH  = 3'd1;
  localparam logic [2:0] S_SEARCH    = 3'd2;
  localparam logic [2:0] S_READ_WAIT = 3'd3;
  localparam logic [2:0] S_SHIFT     = 3'd4;
  localparam logic [2:0] S_SHIFT_END = 3'd5;
  localparam logic [2:0] S_DONE      = 3'd6;

  logic [2:0]             state;
  logic [OPCODE_W-1:0]    op_reg;
  logic [KEY_W-1:0]       key_reg;
  logic [VALUE_WIDTH-1:0] val_reg;
  logic [POS_PORT_W-1:0]  rpos_reg;
  logic [CW-1:0]          fill;
  logic [CW-1:0]          pos_reg;
  logic [AW-1:0]          rd_idx;
  logic [CW-1:0]          sh_left;
  logic                   pend;
  logic [AW-1:0]          pend_dst;

  logic [STATUS_W-1:0]    res_status;
  logic [POS_PORT_W-1:0]  res_slot;
  logic [KEY_W-1:0]       res_key;
  logic [VAL_PORT_W-1:0]  res_value;

  logic                    m_valid;
  logic [STATUS_W-1:0]     o_status;
  logic [POS_PORT_W-1:0]   o_slot;
  logic [KEY_W-1:0]        o_key;
  logic [VAL_PORT_W-1:0]   o_value;
  logic [COUNT_PORT_W-1:0] o_count;

  logic [AW-1:0]          raddr;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [KEY_W-1:0]       wkey;
  logic [VALUE_WIDTH-1:0] wval;
  logic [KEY_W-1:0]       rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;

  logic                   srch_start;
  logic [AW-1:0]          srch_raddr;
  srch_stat_t             srch_stat;
  logic [CW-1:0]          srch_pos;
  logic                   val_same;
  logic                   is_full;
  logic                   in_beat;

  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {o_count, o_value, o_key, o_slot, o_status};
  assign val_same      = (rd_val == val_reg);
  assign is_full       = (fill == CW'(CAPACITY));
  assign srch_start    = (state == S_DISPATCH) && (op_reg == OP_INSERT || op_reg == OP_DELETE);

  sktab_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wkey),
    .raddr (raddr),
    .rdata (rd_key)
  );

  sktab_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wval),
    .raddr (raddr),
    .rdata (rd_val)
  );

  sktab_search #(.CAPACITY(CAPACITY)) u_search (
    .clk    (clk),
    .rst    (rst),
    .start  (srch_start),
    .key    (key_reg),
    .fill   (fill),
    .raddr  (srch_raddr),
    .rd_key (rd_key),
    .stat   (srch_stat),
    .pos    (srch_pos)
  );

  always_comb begin
    raddr = srch_raddr;
    we    = 1'b0;
    waddr = pend_dst;
    wkey  = rd_key;
    wval  = rd_val;
    unique case (state)
      S_DISPATCH: begin
        if (op_reg == OP_READ) begin
          raddr = AW'(rpos_reg);
        end
      end
      S_SEARCH: begin
        // A hit on insert with a new value rewrites that entry in place.
        if (srch_stat.done && op_reg == OP_INSERT && srch_stat.hit && !val_same) begin
          we    = 1'b1;
          waddr = AW'(srch_pos);
          wkey  = key_reg;
          wval  = val_reg;
        end
      end
      S_SHIFT: begin
        raddr = rd_idx;
        we    = pend;
      end
      S_SHIFT_END: begin
        if (op_reg == OP_INSERT) begin
          we    = 1'b1;
          waddr = AW'(pos_reg);
          wkey  = key_reg;
          wval  = val_reg;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fill    <= '0;
      pend    <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!m_valid || m_axis_tready)) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            op_reg     <= s_axis_tdata[1:0];
            key_reg    <= s_axis_tdata[65:2];
            val_reg    <= VALUE_WIDTH'(s_axis_tdata[66 +: KeepW]);
            rpos_reg   <= s_axis_tdata[103:98];
            res_key    <= '0;
            res_value  <= '0;
            res_slot   <= '0;
            res_status <= ST_NOT_FOUND;
            state      <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (op_reg == OP_INSERT || op_reg == OP_DELETE) begin
            state <= S_SEARCH;
          end else if (op_reg == OP_READ) begin
            res_slot <= rpos_reg;
            if (CmpW'(rpos_reg) < CmpW'(fill)) begin
              state <= S_READ_WAIT;
            end else begin
              state <= S_DONE;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_SEARCH: begin
          if (srch_stat.done) begin
            res_slot <= POS_PORT_W'(srch_pos);
            pos_reg  <= srch_pos;
            pend     <= 1'b0;
            if (op_reg == OP_INSERT) begin
              if (srch_stat.hit) begin
                res_status <= val_same ? ST_UNCHANGED : ST_UPDATED;
                state      <= S_DONE;
              end else if (is_full) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                // Move the entry at the slot and those above it up, starting from the top one.
                res_status <= ST_NEW;
                rd_idx     <= AW'(fill - 1'b1);
                sh_left    <= fill - srch_pos;
                state      <= S_SHIFT;
              end
            end else begin
              if (srch_stat.hit) begin
                // Move entries above the slot down, starting just above it.
                res_status <= ST_DELETED;
                rd_idx     <= AW'(srch_pos + 1'b1);
                sh_left    <= fill - srch_pos - 1'b1;
                state      <= S_SHIFT;
              end else begin
                res_status <= ST_NOT_FOUND;
                state      <= S_DONE;
              end
            end
          end
        end
        S_READ_WAIT: begin
          res_key    <= rd_key;
          res_value  <= VAL_PORT_W'(rd_val[KeepW-1:0]);
          res_status <= ST_READ_OK;
          state      <= S_DONE;
        end
        S_SHIFT: begin
          // Each read lands in the next cycle and is written one place over.
          // The write never hits an entry that is still to be read.
          if (sh_left != '0) begin
            pend    <= 1'b1;
            sh_left <= sh_left - 1'b1;
            if (op_reg == OP_INSERT) begin
              pend_dst <= rd_idx + 1'b1;
              rd_idx   <= rd_idx - 1'b1;
            end else begin
              pend_dst <= rd_idx - 1'b1;
              rd_idx   <= rd_idx + 1'b1;
            end
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_SHIFT_END;
            end
          end
        end
        S_SHIFT_END: begin
          if (op_reg == OP_INSERT) begin
            fill <= fill + 1'b1;
          end else begin
            fill <= fill - 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_valid || m_axis_tready) begin
            o_status <= res_status;
            o_slot   <= res_slot;
            o_key    <= res_key;
            o_value  <= res_value;
            o_count  <= COUNT_PORT_W'(fill);
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_fill_change: assert property (@(posedge clk) disable iff (rst)
    !$stable(fill) |-> (state == S_DONE))
    else $error("entry count changed outside the end of an operation");

  a_write_window: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_SEARCH || state == S_SHIFT || state == S_SHIFT_END))
    else $error("table write outside an insert or delete");

  a_search_owner: assert property (@(posedge clk) disable iff (rst)
    srch_stat.done |-> (state == S_SEARCH))
    else $error("search finished with no operation waiting on it");
`endif

endmodule

// File: design/sktab_ram.sv
module sktab_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/sktab_search.sv
module sktab_search
  import sktab_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [KEY_W-1:0]              key,
  input  logic [$clog2(CAPACITY+1)-1:0] fill,
  output logic [$clog2(CAPACITY)-1:0]   raddr,
  input  logic [KEY_W-1:0]              rd_key,
  output srch_stat_t                    stat,
  output logic [$clog2(CAPACITY+1)-1:0] pos
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] SR_IDLE  = 2'd0;
  localparam logic [1:0] SR_LOOP  = 2'd1;
  localparam logic [1:0] SR_WAIT  = 2'd2;
  localparam logic [1:0] SR_PROBE = 2'd3;

  logic [1:0]       st;
  logic [CW-1:0]    lo;
  logic [CW-1:0]    hi;
  logic [CW-1:0]    mid;
  logic [CW-1:0]    mid_c;
  logic [KEY_W-1:0] key_r;

  assign mid_c = lo + ((hi - lo) >> 1);
  assign pos   = lo;

  // Each probe puts the address out in LOOP and takes the key back in WAIT.
  // A final probe at the lower bound tells a hit from a miss.
  always_comb begin
    raddr = AW'(mid_c);
    stat  = '0;
    unique case (st)
      SR_LOOP: begin
        if (lo < hi) begin
          raddr = AW'(mid_c);
        end else if (lo < fill) begin
          raddr = AW'(lo);
        end else begin
          stat.done = 1'b1;
        end
      end
      SR_PROBE: begin
        stat.done = 1'b1;
        stat.hit  = (rd_key == key_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= SR_IDLE;
    end else begin
      unique case (st)
        SR_IDLE: begin
          if (start) begin
            lo    <= '0;
            hi    <= fill;
            key_r <= key;
            st    <= SR_LOOP;
          end
        end
        SR_LOOP: begin
          if (lo < hi) begin
            mid <= mid_c;
            st  <= SR_WAIT;
          end else if (lo < fill) begin
            st <= SR_PROBE;
          end else begin
            st <= SR_IDLE;
          end
        end
        SR_WAIT: begin
          if (rd_key < key_r) begin
            lo <= mid + 1'b1;
          end else begin
            hi <= mid;
          end
          st <= SR_LOOP;
        end
        SR_PROBE: begin
          st <= SR_IDLE;
        end
        default: st <= SR_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    (st == SR_LOOP || st == SR_WAIT) |-> (lo <= hi && hi <= fill))
    else $error("search bounds crossed");
`endif

endmodule
